>>> hdl/psrf_pkg.sv
`timescale 1ns / 1ps

package psrf_pkg;

   // store geometry
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // field widths
   localparam int CFG_W    = 9;
   localparam int CSR_IX_W = 1;
   localparam int POS_W    = 16;
   localparam int EXT_W    = 15;
   localparam int CHAN_W   = 8;
   localparam int PIX_W    = 4 * CHAN_W;

   // working widths
   localparam int SPAN_W = POS_W + 2;
   localparam int PROD_W = ROW_W + CFG_W + COL_W;
   localparam int CCNT_W = CFG_W + COL_W;
   localparam int RCNT_W = CFG_W + ROW_W;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_GET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_FILL  = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'd0,
      CSR_FRAME_HEIGHT = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_READ,
      ST_RESULT
   } state_type;

   typedef struct packed {
      opcode_type               opcode;
      logic signed [POS_W-1:0]  x_pos;
      logic signed [POS_W-1:0]  y_pos;
      logic [EXT_W-1:0]         rect_width;
      logic [EXT_W-1:0]         rect_height;
      logic [PIX_W-1:0]         color;
   } cmd_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  wdata;
   } mem_req_type;

   typedef struct packed {
      logic              read_valid;
      logic [CHAN_W-1:0] read_red;
      logic [CHAN_W-1:0] read_green;
      logic [CHAN_W-1:0] read_blue;
      logic [CHAN_W-1:0] read_alpha;
   } rsp_data_type;

endpackage

>>> hdl/psrf_req_if.sv
`timescale 1ns / 1ps

interface psrf_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            opcode;
   logic signed [psrf_pkg::POS_W-1:0]     x_pos;
   logic signed [psrf_pkg::POS_W-1:0]     y_pos;
   logic [psrf_pkg::EXT_W-1:0]            rect_width;
   logic [psrf_pkg::EXT_W-1:0]            rect_height;
   logic [psrf_pkg::CHAN_W-1:0]           color_red;
   logic [psrf_pkg::CHAN_W-1:0]           color_green;
   logic [psrf_pkg::CHAN_W-1:0]           color_blue;
   logic [psrf_pkg::CHAN_W-1:0]           color_alpha;

   modport source (
      output valid, opcode, x_pos, y_pos, rect_width, rect_height,
             color_red, color_green, color_blue, color_alpha,
      input  ready
   );

   modport sink (
      input  valid, opcode, x_pos, y_pos, rect_width, rect_height,
             color_red, color_green, color_blue, color_alpha,
      output ready
   );
endinterface

>>> hdl/psrf_rsp_if.sv
`timescale 1ns / 1ps

interface psrf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        read_valid;
   logic [psrf_pkg::CHAN_W-1:0] read_red;
   logic [psrf_pkg::CHAN_W-1:0] read_green;
   logic [psrf_pkg::CHAN_W-1:0] read_blue;
   logic [psrf_pkg::CHAN_W-1:0] read_alpha;

   modport source (
      output valid, read_valid, read_red, read_green, read_blue, read_alpha,
      input  ready
   );

   modport sink (
      input  valid, read_valid, read_red, read_green, read_blue, read_alpha,
      output ready
   );
endinterface

>>> hdl/psrf_ram.sv
`timescale 1ns / 1ps

module psrf_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/psrf_seq.sv
`timescale 1ns / 1ps

module psrf_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   output logic                         cmd_ready,
   input  psrf_pkg::cmd_type            cmd,
   input  logic [psrf_pkg::CFG_W-1:0]   frame_w,
   input  logic [psrf_pkg::CFG_W-1:0]   frame_h,
   output psrf_pkg::mem_req_type        mem_req,
   input  logic [psrf_pkg::PIX_W-1:0]   mem_rdata,
   input  logic                         res_room,
   output logic                         res_push,
   output psrf_pkg::rsp_data_type       res_data
);

   psrf_pkg::state_type state_ff, state_in;

   logic [psrf_pkg::PIX_W-1:0] word_ff, word_in;
   logic [psrf_pkg::COL_W-1:0] col_ff, col_in;
   logic [psrf_pkg::COL_W-1:0] col_lo_ff, col_lo_in;
   logic [psrf_pkg::CFG_W-1:0] col_hi_ff, col_hi_in;
   logic [psrf_pkg::ROW_W-1:0] row_ff, row_in;
   logic [psrf_pkg::CFG_W-1:0] row_hi_ff, row_hi_in;
   psrf_pkg::rsp_data_type     res_ff, res_in;

   // pixel address
   logic [psrf_pkg::ROW_W-1:0]  addr_row;
   logic [psrf_pkg::COL_W-1:0]  addr_col;
   logic [psrf_pkg::PROD_W-1:0] addr_full;

   assign addr_row  = (state_ff == psrf_pkg::ST_WALK) ? row_ff
                      : cmd.y_pos[psrf_pkg::ROW_W-1:0];
   assign addr_col  = (state_ff == psrf_pkg::ST_WALK) ? col_ff
                      : cmd.x_pos[psrf_pkg::COL_W-1:0];
   assign addr_full = psrf_pkg::PROD_W'(addr_row) * psrf_pkg::PROD_W'(frame_w)
                      + psrf_pkg::PROD_W'(addr_col);

   // single pixel inside the frame
   logic pix_in_frame;
   assign pix_in_frame = !cmd.x_pos[psrf_pkg::POS_W-1] && !cmd.y_pos[psrf_pkg::POS_W-1]
      && ({1'b0, cmd.x_pos[psrf_pkg::POS_W-2:0]} < psrf_pkg::POS_W'(frame_w))
      && ({1'b0, cmd.y_pos[psrf_pkg::POS_W-2:0]} < psrf_pkg::POS_W'(frame_h));

   // rectangle bounds, clipped to the frame; clear covers the whole frame
   logic signed [psrf_pkg::SPAN_W-1:0] x_s, y_s, x_end, y_end, w_s, h_s;
   logic signed [psrf_pkg::SPAN_W-1:0] x_lo, x_hi, y_lo, y_hi;
   logic                               rect_empty;

   always_comb begin
      x_s   = {{(psrf_pkg::SPAN_W-psrf_pkg::POS_W){cmd.x_pos[psrf_pkg::POS_W-1]}},
               cmd.x_pos};
      y_s   = {{(psrf_pkg::SPAN_W-psrf_pkg::POS_W){cmd.y_pos[psrf_pkg::POS_W-1]}},
               cmd.y_pos};
      x_end = x_s + psrf_pkg::SPAN_W'(cmd.rect_width);
      y_end = y_s + psrf_pkg::SPAN_W'(cmd.rect_height);
      w_s   = {{(psrf_pkg::SPAN_W-psrf_pkg::CFG_W){1'b0}}, frame_w};
      h_s   = {{(psrf_pkg::SPAN_W-psrf_pkg::CFG_W){1'b0}}, frame_h};
      if (cmd.opcode == psrf_pkg::OP_CLEAR) begin
         x_lo = '0;
         y_lo = '0;
         x_hi = w_s;
         y_hi = h_s;
      end else begin
         x_lo = x_s[psrf_pkg::SPAN_W-1] ? '0 : x_s;
         y_lo = y_s[psrf_pkg::SPAN_W-1] ? '0 : y_s;
         x_hi = (x_end > w_s) ? w_s : x_end;
         y_hi = (y_end > h_s) ? h_s : y_end;
      end
      rect_empty = (x_hi <= x_lo) || (y_hi <= y_lo);
   end

   // end of row and end of rectangle
   logic [psrf_pkg::CCNT_W-1:0] col_next;
   logic [psrf_pkg::RCNT_W-1:0] row_next;
   logic                        col_last, row_last;

   assign col_next = psrf_pkg::CCNT_W'(col_ff) + psrf_pkg::CCNT_W'(1);
   assign row_next = psrf_pkg::RCNT_W'(row_ff) + psrf_pkg::RCNT_W'(1);
   assign col_last = (col_next == psrf_pkg::CCNT_W'(col_hi_ff));
   assign row_last = (row_next == psrf_pkg::RCNT_W'(row_hi_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psrf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      col_ff    <= col_in;
      col_lo_ff <= col_lo_in;
      col_hi_ff <= col_hi_in;
      row_ff    <= row_in;
      row_hi_ff <= row_hi_in;
      res_ff    <= res_in;
   end

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      col_in        = col_ff;
      col_lo_in     = col_lo_ff;
      col_hi_in     = col_hi_ff;
      row_in        = row_ff;
      row_hi_in     = row_hi_ff;
      res_in        = res_ff;
      cmd_ready     = 1'b0;
      res_push      = 1'b0;
      res_data      = '0;
      mem_req.wr_en = 1'b0;
      mem_req.rd_en = 1'b0;
      mem_req.addr  = psrf_pkg::ADDR_W'(addr_full);
      mem_req.wdata = word_ff;

      unique case (state_ff)
         psrf_pkg::ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               word_in = cmd.color;
               unique case (cmd.opcode)
                  psrf_pkg::OP_PUT: begin
                     mem_req.wr_en = pix_in_frame;
                     mem_req.wdata = cmd.color;
                     if (res_room) begin
                        res_push = 1'b1;
                     end else begin
                        res_in   = '0;
                        state_in = psrf_pkg::ST_RESULT;
                     end
                  end
                  psrf_pkg::OP_GET: begin
                     if (pix_in_frame) begin
                        mem_req.rd_en = 1'b1;
                        state_in      = psrf_pkg::ST_READ;
                     end else if (res_room) begin
                        res_push = 1'b1;
                     end else begin
                        res_in   = '0;
                        state_in = psrf_pkg::ST_RESULT;
                     end
                  end
                  psrf_pkg::OP_CLEAR,
                  psrf_pkg::OP_FILL: begin
                     if (!rect_empty) begin
                        col_in    = x_lo[psrf_pkg::COL_W-1:0];
                        col_lo_in = x_lo[psrf_pkg::COL_W-1:0];
                        col_hi_in = x_hi[psrf_pkg::CFG_W-1:0];
                        row_in    = y_lo[psrf_pkg::ROW_W-1:0];
                        row_hi_in = y_hi[psrf_pkg::CFG_W-1:0];
                        state_in  = psrf_pkg::ST_WALK;
                     end else if (res_room) begin
                        res_push = 1'b1;
                     end else begin
                        res_in   = '0;
                        state_in = psrf_pkg::ST_RESULT;
                     end
                  end
                  default: ;
               endcase
            end
         end

         psrf_pkg::ST_WALK: begin
            mem_req.wr_en = 1'b1;
            if (col_last) begin
               col_in = col_lo_ff;
               if (row_last) begin
                  if (res_room) begin
                     res_push = 1'b1;
                     state_in = psrf_pkg::ST_IDLE;
                  end else begin
                     res_in   = '0;
                     state_in = psrf_pkg::ST_RESULT;
                  end
               end else begin
                  row_in = row_next[psrf_pkg::ROW_W-1:0];
               end
            end else begin
               col_in = col_next[psrf_pkg::COL_W-1:0];
            end
         end

         psrf_pkg::ST_READ: begin
            // read data is back from the store this cycle
            res_data.read_valid = 1'b1;
            res_data.read_red   = mem_rdata[psrf_pkg::CHAN_W-1:0];
            res_data.read_green = mem_rdata[2*psrf_pkg::CHAN_W-1:psrf_pkg::CHAN_W];
            res_data.read_blue  = mem_rdata[3*psrf_pkg::CHAN_W-1:2*psrf_pkg::CHAN_W];
            res_data.read_alpha = mem_rdata[4*psrf_pkg::CHAN_W-1:3*psrf_pkg::CHAN_W];
            if (res_room) begin
               res_push = 1'b1;
               state_in = psrf_pkg::ST_IDLE;
            end else begin
               res_in   = res_data;
               state_in = psrf_pkg::ST_RESULT;
            end
         end

         psrf_pkg::ST_RESULT: begin
            res_data = res_ff;
            if (res_room) begin
               res_push = 1'b1;
               state_in = psrf_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = psrf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/pixel_store_rect_fill_core.sv
`timescale 1ns / 1ps

// Pixel store of 32-bit RGBA words with put, get, clear and clipped
// rectangle fill. Requests arrive on req_bus, one result per request leaves
// on rsp_bus; both are valid/ready channels. A get returns the pixel with
// read_valid set when it lies inside the frame; every other request returns
// an all-zero result. The frame size is set through the csr_ write port
// (index 0 width, index 1 height), by the user only while the block is
// idle, as the block does not enforce it; values above the store's size
// act as the maximum. One request is worked at a time over the single port
// of the pixel RAM: a put is done in the idle state, a get inside the
// frame adds a read state for the RAM read, and a clear or fill adds a
// walk state writing one pixel inside the frame per cycle. A new request
// is taken while an earlier result still waits in the output register;
// if the receiver stalls, the next result is held inside the sequencer
// and no further request is taken until it has moved on. Reset clears
// the control state and sets the frame to 256 by 256; pixel contents are
// undefined until written and need no clearing pass.
module pixel_store_rect_fill_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [psrf_pkg::CSR_IX_W-1:0]    csr_index,
   input  logic [psrf_pkg::CFG_W-1:0]       csr_wdata,
   psrf_req_if.sink                         req_bus,
   psrf_rsp_if.source                       rsp_bus
);

   logic [psrf_pkg::CFG_W-1:0] frame_w_ff, frame_w_in;
   logic [psrf_pkg::CFG_W-1:0] frame_h_ff, frame_h_in;
   logic [psrf_pkg::CFG_W-1:0] eff_w, eff_h;

   always_comb begin
      frame_w_in = frame_w_ff;
      frame_h_in = frame_h_ff;
      if (csr_we) begin
         unique case (psrf_pkg::csr_index_type'(csr_index))
            psrf_pkg::CSR_FRAME_WIDTH:  frame_w_in = csr_wdata;
            psrf_pkg::CSR_FRAME_HEIGHT: frame_h_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_w_ff <= psrf_pkg::CFG_W'(256);
         frame_h_ff <= psrf_pkg::CFG_W'(256);
      end else begin
         frame_w_ff <= frame_w_in;
         frame_h_ff <= frame_h_in;
      end
   end

   assign eff_w = (32'(frame_w_ff) > psrf_pkg::MAX_WIDTH)
                  ? psrf_pkg::CFG_W'(psrf_pkg::MAX_WIDTH) : frame_w_ff;
   assign eff_h = (32'(frame_h_ff) > psrf_pkg::MAX_HEIGHT)
                  ? psrf_pkg::CFG_W'(psrf_pkg::MAX_HEIGHT) : frame_h_ff;

   psrf_pkg::cmd_type cmd;

   always_comb begin
      cmd.opcode      = psrf_pkg::opcode_type'(req_bus.opcode);
      cmd.x_pos       = req_bus.x_pos;
      cmd.y_pos       = req_bus.y_pos;
      cmd.rect_width  = req_bus.rect_width;
      cmd.rect_height = req_bus.rect_height;
      cmd.color       = {req_bus.color_alpha, req_bus.color_blue,
                         req_bus.color_green, req_bus.color_red};
   end

   psrf_pkg::mem_req_type      mem_req;
   logic [psrf_pkg::PIX_W-1:0] mem_rdata;
   logic                       res_room;
   logic                       res_push;
   psrf_pkg::rsp_data_type     res_data;
   logic                       cmd_ready;

   psrf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_bus.valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .frame_w   (eff_w),
      .frame_h   (eff_h),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata),
      .res_room  (res_room),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   assign req_bus.ready = cmd_ready;

   psrf_ram #(
      .ADDR_W (psrf_pkg::ADDR_W),
      .DATA_W (psrf_pkg::PIX_W)
   ) u_ram (
      .clock (clock),
      .wr_en (mem_req.wr_en),
      .rd_en (mem_req.rd_en),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (mem_rdata)
   );

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   psrf_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   assign res_room = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_valid = rsp_data_ff.read_valid;
   assign rsp_bus.read_red   = rsp_data_ff.read_red;
   assign rsp_bus.read_green = rsp_data_ff.read_green;
   assign rsp_bus.read_blue  = rsp_data_ff.read_blue;
   assign rsp_bus.read_alpha = rsp_data_ff.read_alpha;

endmodule
